// ----- hdl/heart_rate_interval_averager_top_defines.svh -----
// Assertion macros shared by the heart-rate interval averager modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef HEART_RATE_INTERVAL_AVERAGER_TOP_DEFINES_SVH
`define HEART_RATE_INTERVAL_AVERAGER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRIA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRIA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hria_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// heart-rate interval averager. No dependencies.
package hria_pkg;

  localparam int RING_DEPTH = 4;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = 8 + RING_AW;

  localparam int DIV_W      = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] RATE_NUM = 16'd60000;
  localparam logic [7:0]       RATE_MAX = 8'd255;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [15:0] MIN_IVL_RST = 16'd400;
  localparam logic [15:0] MAX_IVL_RST = 16'd1500;
  localparam logic [15:0] TIMEOUT_RST = 16'd3000;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic ring_write;
    logic sum_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic div_last;
    logic sum_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/hria_dp.sv -----
// Datapath of the heart-rate interval averager: config registers, beat
// timing, restoring divider, rate ring, summation and output register. Uses hria_pkg.
`include "heart_rate_interval_averager_top_defines.svh"

module hria_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hria_pkg::cmd_t                 cmd,
  output hria_pkg::sts_t                 sts,
  input  logic [31:0]                    in_now_ms,
  input  logic                           in_beat_seen,
  input  logic                           cfg_valid,
  input  logic [hria_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_average_rate,
  output logic [7:0]                     out_newest_rate,
  output logic                           out_rate_accepted,
  output logic                           out_timed_out
);
  import hria_pkg::*;

  logic [15:0]          min_ivl_r, max_ivl_r, timeout_r;
  logic [31:0]          now_r, diff_r, last_r;
  logic                 beat_r, held_r, acc_r, tmo_r;
  logic [7:0]           ring_r [RING_DEPTH];
  logic [RING_AW-1:0]   pos_r, sum_idx_r;
  logic [DIV_W-1:0]     rem_r, quo_r, dvs_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [7:0]           rate_r, avg_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 out_valid_r, out_acc_r, out_tmo_r;
  logic [7:0]           out_avg_r, out_rate_r;

  logic               ivl_ok, tmo_hit;
  logic [DIV_W:0]     shifted;
  logic [DIV_W+1:0]   trial;
  logic [7:0]         rate_sat, avg_nxt;
  logic [RING_AW-1:0] pos_nxt;

  assign ivl_ok  = beat_r && (diff_r > {16'b0, min_ivl_r}) && (diff_r < {16'b0, max_ivl_r});
  assign tmo_hit = !beat_r && held_r && (diff_r > {16'b0, timeout_r});

  assign shifted  = {rem_r, quo_r[DIV_W-1]};
  assign trial    = {1'b0, shifted} - {2'b0, dvs_r};
  assign rate_sat = (quo_r > {{(DIV_W-8){1'b0}}, RATE_MAX}) ? RATE_MAX : quo_r[7:0];
  assign pos_nxt  = (pos_r == RING_AW'(RING_DEPTH-1)) ? '0 : pos_r + 1'b1;
  assign avg_nxt  = acc_r ? 8'(sum_r / RING_DEPTH) : avg_r;

  assign sts.accept   = ivl_ok;
  assign sts.div_last = (div_cnt_r == DIV_CNT_W'(DIV_W-1));
  assign sts.sum_last = (sum_idx_r == RING_AW'(RING_DEPTH-1));
  assign sts.out_free = !out_valid_r || out_ready;

  // Configuration; an index past the register list writes nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ivl_r <= MIN_IVL_RST;
      max_ivl_r <= MAX_IVL_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_IVL: min_ivl_r <= cfg_data;
        CFG_MAX_IVL: max_ivl_r <= cfg_data;
        CFG_TIMEOUT: timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample capture; the wrapping gap to the last beat is formed here.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= in_now_ms;
      beat_r <= in_beat_seen;
      diff_r <= in_now_ms - last_r;
    end
  end

  // Held beat state, ring and average.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      held_r <= 1'b0;
      pos_r  <= '0;
      avg_r  <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      if (cmd.eval) begin
        if (beat_r) begin
          last_r <= now_r;
          held_r <= 1'b1;
        end else if (tmo_hit) begin
          last_r <= '0;
          held_r <= 1'b0;
          avg_r  <= '0;
          for (int i = 0; i < RING_DEPTH; i++) begin
            ring_r[i] <= '0;
          end
        end
      end
      if (cmd.ring_write) begin
        ring_r[pos_r] <= rate_sat;
        pos_r         <= pos_nxt;
      end
      if (cmd.finish) begin
        avg_r <= avg_nxt;
      end
    end
  end

  // Per-item working registers: flags, divider and ring summation.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      acc_r     <= ivl_ok;
      tmo_r     <= tmo_hit;
      dvs_r     <= diff_r[DIV_W-1:0];
      quo_r     <= RATE_NUM;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!trial[DIV_W+1]) begin
        rem_r <= trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.ring_write) begin
      rate_r    <= rate_sat;
      sum_r     <= '0;
      sum_idx_r <= '0;
    end
    if (cmd.sum_step) begin
      sum_r     <= sum_r + SUM_W'(ring_r[sum_idx_r]);
      sum_idx_r <= sum_idx_r + 1'b1;
    end
  end

  // Output register: a finished beat waits here while the next sample is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_avg_r  <= avg_nxt;
      out_rate_r <= acc_r ? rate_r : 8'd0;
      out_acc_r  <= acc_r;
      out_tmo_r  <= tmo_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average_rate  = out_avg_r;
  assign out_newest_rate   = out_rate_r;
  assign out_rate_accepted = out_acc_r;
  assign out_timed_out     = out_tmo_r;

  `HRIA_ASSERT_NOW(a_no_beat_zero_time, !held_r, last_r == 32'd0, "last beat time not cleared")
  `HRIA_ASSERT_NOW(a_timeout_clears, out_valid_r && out_tmo_r, !out_acc_r && (out_avg_r == 8'd0), "timeout beat carries a rate or average")
  `HRIA_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid_r, "finished beat not presented")

endmodule

// ----- hdl/hria_ctrl.sv -----
// Controller of the heart-rate interval averager: sequences capture,
// evaluation, division, ring update, summation and result hand-off. Uses hria_pkg.
`include "heart_rate_interval_averager_top_defines.svh"

module hria_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hria_pkg::sts_t sts,
  output hria_pkg::cmd_t cmd
);
  import hria_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_DIV   = 6'b000100,
    S_WRITE = 6'b001000,
    S_SUM   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.accept ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.ring_write = 1'b1;
        state_nxt      = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `HRIA_ASSERT_NEXT(a_done_waits, (state_r == S_DONE) && !sts.out_free,
                    state_r == S_DONE, "result dropped while output busy")
  `HRIA_ASSERT_NEXT(a_div_to_write, (state_r == S_DIV) && sts.div_last,
                    cmd.ring_write, "ring not written after divide")
  `HRIA_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_r), "state register not one-hot")

endmodule

// ----- hdl/heart_rate_interval_averager_top.sv -----
// Sequence: an accepted beat in the window runs eval, a 16-step restoring divide for
// 60000/interval, a ring write and a summation over the ring entries before its result is
// presented; any other sample goes from eval straight to the result. The next sample is
// taken once the controller is back in idle after the result is loaded into the output
// register, later while the previous result still waits in the output register.
// Synchronous active-low reset restores default windows and clears ring, average and held beat.
module heart_rate_interval_averager_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_now_ms,
  input  logic                           in_beat_seen,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_average_rate,
  output logic [7:0]                     out_newest_rate,
  output logic                           out_rate_accepted,
  output logic                           out_timed_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hria_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import hria_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hria_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hria_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_now_ms         (in_now_ms),
    .in_beat_seen      (in_beat_seen),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_average_rate  (out_average_rate),
    .out_newest_rate   (out_newest_rate),
    .out_rate_accepted (out_rate_accepted),
    .out_timed_out     (out_timed_out)
  );

endmodule
